### hdl/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared types, message codes and decode helpers for the MIDI byte parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mbsp_pkg;

   // Longest sysex chunk handed out before a chunk word is emitted.
   localparam int CHUNK_LEN = 128;
   // Width of the sysex byte counter; it must be able to hold CHUNK_LEN.
   localparam int CNT_W     = $clog2(CHUNK_LEN + 1);

   // Message type codes, in the usual MIDI order.
   localparam logic [3:0] MSG_NOTEOFF     = 4'd0;
   localparam logic [3:0] MSG_NOTEON      = 4'd1;
   localparam logic [3:0] MSG_POLYPRESS   = 4'd2;
   localparam logic [3:0] MSG_CC          = 4'd3;
   localparam logic [3:0] MSG_PROGRAM     = 4'd4;
   localparam logic [3:0] MSG_CHANPRESS   = 4'd5;
   localparam logic [3:0] MSG_PITCHBEND   = 4'd6;
   localparam logic [3:0] MSG_SYSCOMMON   = 4'd7;
   localparam logic [3:0] MSG_REALTIME    = 4'd8;
   localparam logic [3:0] MSG_CHANMODE    = 4'd9;
   localparam logic [3:0] MSG_NONE        = 4'd10;

   // System common subtypes that carry data bytes.
   localparam logic [2:0] CK_SYSEX        = 3'd0;
   localparam logic [2:0] CK_MTC_QFRAME   = 3'd1;
   localparam logic [2:0] CK_SONG_POS     = 3'd2;
   localparam logic [2:0] CK_SONG_SEL     = 3'd3;

   // Sysex chunk kinds.
   localparam logic [1:0] CHUNK_SINGLE    = 2'd0;
   localparam logic [1:0] CHUNK_FIRST     = 2'd1;
   localparam logic [1:0] CHUNK_MIDDLE    = 2'd2;
   localparam logic [1:0] CHUNK_LAST      = 2'd3;

   // Special byte values and controller thresholds.
   localparam logic [7:0] BYTE_RT_FIRST   = 8'hF8;
   localparam logic [7:0] BYTE_EOX        = 8'hF7;
   localparam logic [6:0] CC_LAST_NORMAL  = 7'd119;
   localparam logic [6:0] CC_MODE_BASE    = 7'd120;
   localparam logic [2:0] HI_NIBBLE_SYS   = 3'b111;

   // Parser phase, one-hot.
   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_STATUS = 4'b0010,
      PH_DATA0  = 4'b0100,
      PH_SYSEX  = 4'b1000
   } phase_type;

   // One result word; event_valid sits in the lowest bit.
   typedef struct packed {
      logic       sysex_flush;
      logic       sysex_write;
      logic [7:0] chunk_length;
      logic [1:0] chunk_kind;
      logic [2:0] mode_kind;
      logic [2:0] realtime_kind;
      logic [2:0] common_kind;
      logic [6:0] second_data;
      logic [6:0] first_data;
      logic [3:0] midi_channel;
      logic [3:0] msg_type;
      logic       event_valid;
   } result_type;

   // Result word with no event.
   function automatic result_type no_event();
      result_type r;
      r          = '0;
      r.msg_type = MSG_NONE;
      return r;
   endfunction

   // Build the event word for a completed channel or system common message.
   function automatic result_type emit_msg(input logic [3:0] msg,
                                           input logic [3:0] chan,
                                           input logic [6:0] first,
                                           input logic [6:0] second,
                                           input logic [2:0] common);
      result_type r;
      logic [6:0] mode_diff;
      r           = '0;
      mode_diff   = first - CC_MODE_BASE;
      r.event_valid = 1'b1;
      r.msg_type  = msg;
      if (msg == MSG_SYSCOMMON) begin
         r.common_kind = common;
         if (common == CK_MTC_QFRAME || common == CK_SONG_SEL) begin
            r.first_data = first;
         end else if (common == CK_SONG_POS) begin
            r.first_data  = first;
            r.second_data = second;
         end
      end else begin
         r.midi_channel = chan;
         r.first_data   = first;
         if (msg != MSG_PROGRAM && msg != MSG_CHANPRESS) begin
            r.second_data = second;
         end
         if (msg == MSG_CHANMODE) begin
            r.mode_kind = mode_diff[2:0];
         end
      end
      return r;
   endfunction

   // Build a sysex chunk word; the length keeps the low eight bits of the count.
   function automatic result_type emit_chunk(input logic [1:0]       kind,
                                             input logic [CNT_W-1:0] count);
      result_type           r;
      logic [CNT_W+7:0]     wide;
      r              = no_event();
      wide           = {8'd0, count};
      r.event_valid  = 1'b1;
      r.msg_type     = MSG_SYSCOMMON;
      r.chunk_kind   = kind;
      r.chunk_length = wide[7:0];
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/midi_byte_stream_parser.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Running status MIDI parser with sysex chunk framing, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one received MIDI byte per word together with a
// flag that says whether the external sysex buffer can take another byte.
// The rsp channel returns exactly one word for every accepted byte: an event
// flag, the decoded message and the sysex write and flush strobes that the
// buffer logic must apply for that byte.
// The result of a byte is registered at the edge that accepts it, in the
// output register or, while an output word waits, in the skid register.
// Throughput is one word per cycle while the receiver does not stall; the
// decode is a single pass of logic from parser state to result register.
// The result side has an output register and a one-word skid register, so a
// byte is still taken while a finished result waits. When the receiver stalls
// and both hold a word, req_tready falls until rsp_tready returns.
// Reset clears the parser to idle with no running status, empties both result
// registers and drops req_tready only while reset is held.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_byte_stream_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // rx_byte[7:0], sysex_room[8], zero[15:9]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // event_valid[0], msg_type[4:1],
                                         // midi_channel[8:5], first_data[15:9],
                                         // second_data[22:16], common_kind[25:23],
                                         // realtime_kind[28:26], mode_kind[31:29],
                                         // chunk_kind[33:32], chunk_length[41:34],
                                         // sysex_write[42], sysex_flush[43],
                                         // zero[47:44]
);

   // Parser state.
   mbsp_pkg::phase_type         phase_ff,    phase_in;
   logic [3:0]                  running_ff,  running_in;
   logic [3:0]                  cur_type_ff, cur_type_in;
   logic [3:0]                  channel_ff,  channel_in;
   logic [6:0]                  first_ff,    first_in;
   logic [2:0]                  common_ff,   common_in;
   logic [mbsp_pkg::CNT_W-1:0]  count_ff,    count_in;
   logic                        in_seq_ff,   in_seq_in;
   logic                        ovf_ff,      ovf_in;

   // Result buffering.
   mbsp_pkg::result_type        out_ff,  out_in;
   logic                        out_valid_ff, out_valid_in;
   mbsp_pkg::result_type        skid_ff, skid_in;
   logic                        skid_valid_ff, skid_valid_in;

   mbsp_pkg::result_type        res;
   logic [7:0]                  rx_byte;
   logic                        sysex_room;
   logic [6:0]                  data7;
   logic                        req_fire;
   logic                        out_free;

   // Data byte decode shared by running status and explicit status.
   logic [3:0]                  take_base;
   logic [3:0]                  take_type;
   logic                        take_one;
   logic [mbsp_pkg::CNT_W-1:0]  count_inc;

   localparam logic [mbsp_pkg::CNT_W-1:0] ChunkMax = mbsp_pkg::CNT_W'(mbsp_pkg::CHUNK_LEN);

   assign rx_byte    = req_tdata[7:0];
   assign sysex_room = req_tdata[8];
   assign data7      = rx_byte[6:0];

   assign req_tready = !reset && !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff};

   // Type used by the first data byte, with high controllers turned into mode messages.
   always_comb begin
      take_base = (phase_ff == mbsp_pkg::PH_IDLE) ? running_ff : cur_type_ff;
      if (take_base == mbsp_pkg::MSG_CC && data7 > mbsp_pkg::CC_LAST_NORMAL) begin
         take_type = mbsp_pkg::MSG_CHANMODE;
      end else begin
         take_type = take_base;
      end
      take_one = (take_type == mbsp_pkg::MSG_PROGRAM) ||
                 (take_type == mbsp_pkg::MSG_CHANPRESS) ||
                 (take_type == mbsp_pkg::MSG_SYSCOMMON &&
                  (common_ff == mbsp_pkg::CK_MTC_QFRAME ||
                   common_ff == mbsp_pkg::CK_SONG_SEL));
      count_inc = count_ff + 1'b1;
   end

   // Decode one byte against the parser state.
   always_comb begin
      phase_in    = phase_ff;
      running_in  = running_ff;
      cur_type_in = cur_type_ff;
      channel_in  = channel_ff;
      first_in    = first_ff;
      common_in   = common_ff;
      count_in    = count_ff;
      in_seq_in   = in_seq_ff;
      ovf_in      = ovf_ff;
      res         = mbsp_pkg::no_event();

      if (rx_byte >= mbsp_pkg::BYTE_RT_FIRST) begin
         // Real-time bytes pass through any phase without touching the state.
         res.event_valid   = 1'b1;
         res.msg_type      = mbsp_pkg::MSG_REALTIME;
         res.realtime_kind = rx_byte[2:0];
      end else if (phase_ff == mbsp_pkg::PH_SYSEX) begin
         // Inside sysex: store, frame into chunks, or close the sequence.
         if (rx_byte == mbsp_pkg::BYTE_EOX) begin
            if (ovf_ff) begin
               res.sysex_flush = 1'b1;
            end else begin
               res = mbsp_pkg::emit_chunk(in_seq_ff ? mbsp_pkg::CHUNK_LAST :
                                          mbsp_pkg::CHUNK_SINGLE, count_ff);
            end
            count_in  = '0;
            in_seq_in = 1'b0;
            ovf_in    = 1'b0;
            phase_in  = mbsp_pkg::PH_IDLE;
         end else if (!ovf_ff && sysex_room) begin
            res.sysex_write = 1'b1;
            if (count_inc >= ChunkMax) begin
               res = mbsp_pkg::emit_chunk(in_seq_ff ? mbsp_pkg::CHUNK_MIDDLE :
                                          mbsp_pkg::CHUNK_FIRST, count_inc);
               res.sysex_write = 1'b1;
               count_in  = '0;
               in_seq_in = 1'b1;
            end else begin
               count_in = count_inc;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end else if (rx_byte[7]) begin
         // Status byte: system common cancels running status.
         cur_type_in = {1'b0, rx_byte[6:4]};
         if (rx_byte[6:4] == mbsp_pkg::HI_NIBBLE_SYS) begin
            channel_in = '0;
            running_in = mbsp_pkg::MSG_NONE;
            common_in  = rx_byte[2:0];
            if (rx_byte[2:0] == mbsp_pkg::CK_SYSEX) begin
               phase_in = mbsp_pkg::PH_SYSEX;
            end else if (rx_byte[2:0] > mbsp_pkg::CK_SONG_SEL) begin
               res = mbsp_pkg::emit_msg(mbsp_pkg::MSG_SYSCOMMON, 4'd0, first_ff,
                                        7'd0, rx_byte[2:0]);
               phase_in = mbsp_pkg::PH_IDLE;
            end else begin
               phase_in = mbsp_pkg::PH_STATUS;
            end
         end else begin
            channel_in = rx_byte[3:0];
            running_in = {1'b0, rx_byte[6:4]};
            phase_in   = mbsp_pkg::PH_STATUS;
         end
      end else begin
         // Data byte.
         case (phase_ff)
            mbsp_pkg::PH_IDLE, mbsp_pkg::PH_STATUS: begin
               if (phase_ff == mbsp_pkg::PH_STATUS || running_ff != mbsp_pkg::MSG_NONE) begin
                  cur_type_in = take_type;
                  first_in    = data7;
                  if (take_one) begin
                     res = mbsp_pkg::emit_msg(take_type, channel_ff, data7, 7'd0,
                                              common_ff);
                     phase_in = mbsp_pkg::PH_IDLE;
                  end else begin
                     phase_in = mbsp_pkg::PH_DATA0;
                  end
               end
            end
            mbsp_pkg::PH_DATA0: begin
               if (cur_type_ff == mbsp_pkg::MSG_NOTEON && data7 == 7'd0) begin
                  cur_type_in = mbsp_pkg::MSG_NOTEOFF;
               end
               res = mbsp_pkg::emit_msg(cur_type_in, channel_ff, first_ff, data7,
                                        common_ff);
               phase_in = mbsp_pkg::PH_IDLE;
            end
            default: begin
               phase_in = mbsp_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Output register with a one-word skid stage behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = req_fire;
         end
      end else if (req_fire) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   // Parser state registers advance only on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= mbsp_pkg::PH_IDLE;
         running_ff  <= mbsp_pkg::MSG_NONE;
         cur_type_ff <= mbsp_pkg::MSG_NONE;
         channel_ff  <= '0;
         first_ff    <= '0;
         common_ff   <= '0;
         count_ff    <= '0;
         in_seq_ff   <= 1'b0;
         ovf_ff      <= 1'b0;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         running_ff  <= running_in;
         cur_type_ff <= cur_type_in;
         channel_ff  <= channel_in;
         first_ff    <= first_in;
         common_ff   <= common_in;
         count_ff    <= count_in;
         in_seq_ff   <= in_seq_in;
         ovf_ff      <= ovf_in;
      end
   end

   // Result handshake control.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   // The skid stage only fills behind a waiting output word.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   // Overflow is only remembered while a sysex sequence is open.
   a_ovf_in_sysex: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (phase_ff == mbsp_pkg::PH_SYSEX))
      else $error("sysex overflow flag set outside sysex");

   // Chunk framing state never survives the end of a sysex sequence.
   a_chunk_in_sysex: assert property (@(posedge clock) disable iff (reset)
      (in_seq_ff || count_ff != '0) |-> (phase_ff == mbsp_pkg::PH_SYSEX))
      else $error("chunk state left over outside sysex");

   // The byte counter emits a chunk before reaching the chunk length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < ChunkMax)
      else $error("sysex byte counter reached the chunk length");
`endif

endmodule

`default_nettype wire
